/* sv/hsf_pkg.sv */
// Package with widths, latencies and sideband types for the spring force pipeline.
package hsf_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned CfgW     = 31;
  localparam int unsigned MagW     = 33;
  localparam int unsigned SumW     = 66;
  localparam int unsigned RootW    = 35;
  localparam int unsigned TrialW   = 70;
  localparam int unsigned QuoW     = 31;
  localparam int unsigned DivRemW  = 35;
  localparam int unsigned DivLat   = 32;
  localparam int unsigned ForceMW  = 50;
  localparam int unsigned HalfMW   = 25;
  localparam int unsigned PartW    = 56;
  localparam int unsigned FullW    = 81;
  localparam int unsigned FracShft = 30;

  localparam logic [7:0] RegRestLength    = 8'd0;
  localparam logic [7:0] RegSpringConst   = 8'd1;

  typedef struct packed {
    logic [2:0]         neg_d;
    logic               neg_stretch;
    logic               zero_len;
    logic [ForceMW-1:0] mag;
  } side_t;

endpackage

/* sv/hooke_spring_force_3d_unit.sv */
// Top level of the pipelined three-dimensional Hooke spring force unit.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid_i/tready_o     tdata: start x,y,z, end x,y,z
//  m_axis    out        m_axis_tvalid_o/tready_i     tdata: force x,y,z; tuser: saturated
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while the output is not stalled; the 35-stage square
// root and the 32-stage divider set the depth up to the output register.
// Reset clears all valid bits and sets the configuration registers to their defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module hooke_spring_force_3d_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // force_x, force_y, force_z
  output logic [95:0]  m_axis_tdata_o,
  // saturated
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned Steps = hsf_pkg::RootW;

  logic en;
  logic [hsf_pkg::CfgW-1:0] rest_q, kspr_q;

  assign cfg_ready_o     = 1'b1;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= '0;
      kspr_q <= hsf_pkg::CfgW'(65536);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == hsf_pkg::RegRestLength) begin
        rest_q <= cfg_data_i[hsf_pkg::CfgW-1:0];
      end else if (cfg_index_i == hsf_pkg::RegSpringConst) begin
        kspr_q <= cfg_data_i[hsf_pkg::CfgW-1:0];
      end
    end
  end

  // Difference and magnitude.
  logic                     a_vld_q;
  logic [hsf_pkg::MagW-1:0] a_ad_q [3];
  logic [2:0]               a_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid_i;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_diff
    logic signed [hsf_pkg::MagW-1:0] d;
    assign d = $signed({s_axis_tdata_i[96+32*i+31], s_axis_tdata_i[96+32*i +: 32]})
             - $signed({s_axis_tdata_i[32*i+31], s_axis_tdata_i[32*i +: 32]});
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_ad_q[i]  <= d[hsf_pkg::MagW-1] ? hsf_pkg::MagW'(-d) : hsf_pkg::MagW'(d);
        a_neg_q[i] <= d[hsf_pkg::MagW-1];
      end
    end
  end

  // Squares.
  logic                     b_vld_q;
  logic [hsf_pkg::SumW-1:0] b_sq_q [3];
  logic [hsf_pkg::MagW-1:0] b_ad_q [3];
  logic [2:0]               b_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_q[i] <= hsf_pkg::SumW'(a_ad_q[i]) * hsf_pkg::SumW'(a_ad_q[i]);
        b_ad_q[i] <= a_ad_q[i];
      end
      b_neg_q <= a_neg_q;
    end
  end

  // Sum of squares, then the digit-by-digit square root.
  logic                      r_vld_q  [Steps+1];
  logic [hsf_pkg::SumW-1:0]  r_rem_q  [Steps+1];
  logic [hsf_pkg::RootW-1:0] r_root_q [Steps+1];
  logic [hsf_pkg::MagW-1:0]  r_ad_q   [Steps+1][3];
  logic [2:0]                r_neg_q  [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q[0] <= 1'b0;
    end else if (en) begin
      r_vld_q[0] <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_rem_q[0]  <= b_sq_q[0] + b_sq_q[1] + b_sq_q[2];
      r_root_q[0] <= '0;
      r_ad_q[0]   <= b_ad_q;
      r_neg_q[0]  <= b_neg_q;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_root
    localparam int unsigned Bit = Steps - 1 - j;
    logic [hsf_pkg::TrialW-1:0] trial, rem_w;
    logic                       take;
    assign trial = (hsf_pkg::TrialW'(r_root_q[j]) << (Bit + 1))
                 + (hsf_pkg::TrialW'(1) << (2 * Bit));
    assign rem_w = hsf_pkg::TrialW'(r_rem_q[j]);
    assign take  = rem_w >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        r_vld_q[j+1] <= r_vld_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        r_rem_q[j+1]  <= take ? hsf_pkg::SumW'(rem_w - trial) : r_rem_q[j];
        r_root_q[j+1] <= take ? (r_root_q[j] | (hsf_pkg::RootW'(1) << Bit)) : r_root_q[j];
        r_ad_q[j+1]   <= r_ad_q[j];
        r_neg_q[j+1]  <= r_neg_q[j];
      end
    end
  end

  // Force magnitude alongside the three dividers.
  logic [hsf_pkg::RootW-1:0] len;
  logic                      neg_str;
  logic [hsf_pkg::RootW-1:0] str_mag;
  logic [65:0]               kprod;
  logic                      s_vld_q  [hsf_pkg::DivLat];
  hsf_pkg::side_t            s_side_q [hsf_pkg::DivLat];
  logic [hsf_pkg::QuoW-1:0]  quo      [3];

  assign len     = r_root_q[Steps];
  assign neg_str = len < hsf_pkg::RootW'(rest_q);
  assign str_mag = neg_str ? hsf_pkg::RootW'(rest_q) - len : len - hsf_pkg::RootW'(rest_q);
  assign kprod   = 66'(kspr_q) * 66'(str_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q[0] <= 1'b0;
    end else if (en) begin
      s_vld_q[0] <= r_vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_side_q[0].neg_d       <= r_neg_q[Steps];
      s_side_q[0].neg_stretch <= neg_str;
      s_side_q[0].zero_len    <= len == '0;
      s_side_q[0].mag         <= kprod[16 +: hsf_pkg::ForceMW];
    end
  end

  for (genvar k = 1; k < hsf_pkg::DivLat; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_vld_q[k] <= 1'b0;
      end else if (en) begin
        s_vld_q[k] <= s_vld_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_side_q[k] <= s_side_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    hsf_divider u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (r_ad_q[Steps][i]),
      .den_i (len),
      .quo_o (quo[i])
    );
  end

  // Partial products of magnitude times unit component.
  localparam int unsigned Last = hsf_pkg::DivLat - 1;
  logic                      p_vld_q;
  hsf_pkg::side_t            p_side_q;
  logic [hsf_pkg::PartW-1:0] p_lo_q [3];
  logic [hsf_pkg::PartW-1:0] p_hi_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= s_vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side_q <= s_side_q[Last];
      for (int i = 0; i < 3; i++) begin
        p_lo_q[i] <= hsf_pkg::PartW'(s_side_q[Last].mag[hsf_pkg::HalfMW-1:0]) *
                     hsf_pkg::PartW'(quo[i]);
        p_hi_q[i] <= hsf_pkg::PartW'(s_side_q[Last].mag[hsf_pkg::ForceMW-1:hsf_pkg::HalfMW]) *
                     hsf_pkg::PartW'(quo[i]);
      end
    end
  end

  // Combine, sign and saturate into the output register.
  logic        o_vld_q;
  logic [31:0] o_force_q [3];
  logic        o_sat_q;
  logic [31:0] f_out [3];
  logic [2:0]  f_sat;

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [hsf_pkg::FullW-1:0] full;
    logic [hsf_pkg::FullW-1:0] fmag;
    logic                      neg;
    assign full = (hsf_pkg::FullW'(p_hi_q[i]) << hsf_pkg::HalfMW) + hsf_pkg::FullW'(p_lo_q[i]);
    assign fmag = full >> hsf_pkg::FracShft;
    assign neg  = p_side_q.neg_stretch != p_side_q.neg_d[i];
    always_comb begin
      f_sat[i] = 1'b0;
      f_out[i] = '0;
      if (p_side_q.zero_len) begin
        f_out[i] = '0;
      end else if (neg) begin
        if (fmag > hsf_pkg::FullW'(33'h080000000)) begin
          f_sat[i] = 1'b1;
          f_out[i] = 32'h80000000;
        end else begin
          f_out[i] = 32'(-fmag[31:0]);
        end
      end else begin
        if (fmag > hsf_pkg::FullW'(32'h7fffffff)) begin
          f_sat[i] = 1'b1;
          f_out[i] = 32'h7fffffff;
        end else begin
          f_out[i] = fmag[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_force_q <= f_out;
      o_sat_q   <= |f_sat;
    end
  end

  assign m_axis_tvalid_o = o_vld_q;
  assign m_axis_tdata_o  = {o_force_q[2], o_force_q[1], o_force_q[0]};
  assign m_axis_tuser_o  = o_sat_q;

endmodule

/* sv/hsf_divider.sv */
// Pipelined restoring divider: quotient of (num << 30) / den, one bit per stage.
module hsf_divider (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [hsf_pkg::MagW-1:0]             num_i,
  input  logic [hsf_pkg::RootW-1:0]            den_i,
  output logic [hsf_pkg::QuoW-1:0]             quo_o
);

  logic [hsf_pkg::DivRemW-1:0] rem_q [hsf_pkg::DivLat];
  logic [hsf_pkg::QuoW-1:0]    quo_q [hsf_pkg::DivLat];
  logic [hsf_pkg::RootW-1:0]   den_q [hsf_pkg::DivLat];
  logic                        lsb_q [hsf_pkg::DivLat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hsf_pkg::DivRemW'(num_i >> 1);
      lsb_q[0] <= num_i[0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 1; k < hsf_pkg::DivLat; k++) begin : g_step
    logic [hsf_pkg::DivRemW:0] shifted;
    logic                      take;
    assign shifted = {rem_q[k-1], (k == 1) ? lsb_q[k-1] : 1'b0};
    assign take    = shifted >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? hsf_pkg::DivRemW'(shifted - {1'b0, den_q[k-1]})
                         : hsf_pkg::DivRemW'(shifted);
        quo_q[k] <= {quo_q[k-1][hsf_pkg::QuoW-2:0], take};
        lsb_q[k] <= 1'b0;
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[hsf_pkg::DivLat-1];

endmodule

/* sv/hsf_checker.sv */
// Port-level checker for the spring force unit, bound to the top level.
module hsf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [95:0]  m_axis_tdata_o,
  input logic [0:0]   m_axis_tuser_o
);

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow the output stage");

  a_sat_means_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o[31:0] == 32'h7fffffff || m_axis_tdata_o[31:0] == 32'h80000000 ||
       m_axis_tdata_o[63:32] == 32'h7fffffff || m_axis_tdata_o[63:32] == 32'h80000000 ||
       m_axis_tdata_o[95:64] == 32'h7fffffff || m_axis_tdata_o[95:64] == 32'h80000000))
    else $error("saturated item without a clamped component");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output item changed");

endmodule

bind hooke_spring_force_3d_unit hsf_checker u_hsf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
